[hdl/u8l1_pkg.sv]
`default_nettype none
package u8l1_pkg;

  // Width of the running output count.
  localparam int COUNT_WIDTH = 10;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Compare width for count against the limit; holds count + 3 and the limit.
  localparam int CMP_WIDTH = COUNT_WIDTH + 2;

  // Field widths of the channels and the configuration port.
  localparam int BYTE_WIDTH = 8;
  localparam int OUT_COUNT_WIDTH = 10;
  localparam int LIMIT_WIDTH = 10;
  localparam int CFG_DATA_WIDTH = 10;
  localparam int CFG_INDEX_WIDTH = 1;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

  // Register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIRECTION = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LENGTH_LIMIT = 1'd1;

  // Directions.
  localparam logic DIR_DECODE = 1'b0;
  localparam logic DIR_ENCODE = 1'b1;

  // Substitute character for unmappable input.
  localparam logic [BYTE_WIDTH-1:0] SUBST_CHAR = 8'h3F;

  // One queue entry: up to two result items produced by one input item.
  typedef struct packed {
    logic [BYTE_WIDTH-1:0]  ch0;
    logic [COUNT_WIDTH-1:0] cnt0;
    logic                   last0;
    logic [BYTE_WIDTH-1:0]  ch1;
    logic [COUNT_WIDTH-1:0] cnt1;
    logic                   last1;
    logic                   two;
  } u8l1_entry_t;

endpackage
`default_nettype wire

[hdl/u8l1_if.sv]
`default_nettype none
// Input channel: one source byte or an end-of-string mark per item.
interface u8l1_in_if;
  logic                           valid;
  logic                           ready;
  logic [u8l1_pkg::BYTE_WIDTH-1:0] data_byte;
  logic                           end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink (input valid, input data_byte, input end_of_string, output ready);
endinterface

// Output channel: one converted byte or the final count per item.
interface u8l1_out_if;
  logic                                valid;
  logic                                ready;
  logic [u8l1_pkg::BYTE_WIDTH-1:0]      out_byte;
  logic [u8l1_pkg::OUT_COUNT_WIDTH-1:0] emitted_count;
  logic                                is_last;

  modport source (output valid, output out_byte, output emitted_count, output is_last,
                  input ready);
  modport sink (input valid, input out_byte, input emitted_count, input is_last,
                output ready);
endinterface
`default_nettype wire

[hdl/utf8_latin1_name_transcoder.sv]
`default_nettype none
// Channel   Role   Item
// in_ch     sink   data_byte, end_of_string
// out_ch    source out_byte, emitted_count, is_last
// cfg_*     write  index 0 direction, index 1 length_limit
//
// One input item is taken per cycle while the four-entry queue has room.
// The output side gives one item per cycle while out_ch is ready; an encoded byte
// of 0x80 or above and a cut-short sequence at the end give two, so the sustained
// rate there is set by the single output register: one result item per cycle.
// Reset is synchronous and clears the state, the queue and the output.
// A stalled output fills the queue, and then the input stalls.
module utf8_latin1_name_transcoder (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [u8l1_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [u8l1_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  u8l1_in_if.sink                                   in_ch,
  u8l1_out_if.source                                out_ch
);
  import u8l1_pkg::*;

  logic        take;
  logic        push;
  logic        full;
  logic        q_valid;
  logic        q_pop;
  u8l1_entry_t push_data;
  u8l1_entry_t q_data;

  assign in_ch.ready = !full;
  assign take        = in_ch.valid && !full;

  u8l1_front front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .take          (take),
    .data_byte     (in_ch.data_byte),
    .end_of_string (in_ch.end_of_string),
    .push          (push),
    .entry         (push_data)
  );

  u8l1_queue queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  u8l1_back back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

[hdl/u8l1_front.sv]
`default_nettype none
module u8l1_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [u8l1_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [u8l1_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  wire logic                                 take,
  input  wire logic [u8l1_pkg::BYTE_WIDTH-1:0]      data_byte,
  input  wire logic                                 end_of_string,
  output      logic                                 push,
  output      u8l1_pkg::u8l1_entry_t                entry
);
  import u8l1_pkg::*;

  logic                   direction;
  logic [LIMIT_WIDTH-1:0] length_limit;

  logic [1:0]             pend, pend_next;
  logic [20:0]            acc, acc_next;
  logic [COUNT_WIDTH-1:0] cnt, cnt_next;
  logic                   lim, lim_next;

  logic [COUNT_WIDTH-1:0] cnt_p1, cnt_p2;
  logic [CMP_WIDTH-1:0]   cnt_ext, limit_ext, eff_limit;
  logic [20:0]            acc_shift;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      direction    <= DIR_DECODE;
      length_limit <= LIMIT_WIDTH'(255);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIRECTION:    direction <= cfg_data[0];
        REG_LENGTH_LIMIT: length_limit <= cfg_data[LIMIT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Conversion state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      acc  <= '0;
      cnt  <= '0;
      lim  <= 1'b0;
    end else begin
      pend <= pend_next;
      acc  <= acc_next;
      cnt  <= cnt_next;
      lim  <= lim_next;
    end
  end

  // Counts, the effective limit and the next accumulator value.
  assign cnt_p1    = cnt + COUNT_WIDTH'(1);
  assign cnt_p2    = cnt + COUNT_WIDTH'(2);
  assign cnt_ext   = CMP_WIDTH'(cnt);
  assign limit_ext = CMP_WIDTH'(length_limit);
  assign eff_limit = (limit_ext < CMP_WIDTH'(COUNT_MAX)) ? limit_ext : CMP_WIDTH'(COUNT_MAX);
  assign acc_shift = {acc[14:0], data_byte[5:0]};

  // Classify the item, update the state and build the queue entry.
  always_comb begin
    pend_next = pend;
    acc_next  = acc;
    cnt_next  = cnt;
    lim_next  = lim;
    entry     = '0;
    push      = 1'b0;
    if (take) begin
      if (end_of_string) begin
        push = 1'b1;
        if (direction == DIR_DECODE && pend != 2'd0) begin
          entry.ch0   = SUBST_CHAR;
          entry.cnt0  = cnt_p1;
          entry.cnt1  = cnt_p1;
          entry.last1 = 1'b1;
          entry.two   = 1'b1;
        end else begin
          entry.cnt0  = cnt;
          entry.last0 = 1'b1;
        end
        pend_next = '0;
        acc_next  = '0;
        cnt_next  = '0;
        lim_next  = 1'b0;
      end else if (direction == DIR_ENCODE) begin
        pend_next = '0;
        acc_next  = '0;
        if (lim || (cnt_ext + CMP_WIDTH'(3) >= eff_limit)) begin
          lim_next = 1'b1;
        end else if (!data_byte[7]) begin
          push       = 1'b1;
          entry.ch0  = data_byte;
          entry.cnt0 = cnt_p1;
          cnt_next   = cnt_p1;
        end else begin
          push       = 1'b1;
          entry.ch0  = 8'hC0 | {6'b0, data_byte[7:6]};
          entry.cnt0 = cnt_p1;
          entry.ch1  = 8'h80 | {2'b0, data_byte[5:0]};
          entry.cnt1 = cnt_p2;
          entry.two  = 1'b1;
          cnt_next   = cnt_p2;
        end
      end else if (pend != 2'd0) begin
        // Continuation byte: its low six bits go in unchecked.
        pend_next = pend - 2'd1;
        if (pend == 2'd1) begin
          push       = 1'b1;
          entry.ch0  = (acc_shift < 21'h100) ? acc_shift[7:0] : SUBST_CHAR;
          entry.cnt0 = cnt_p1;
          cnt_next   = cnt_p1;
          acc_next   = '0;
        end else begin
          acc_next = acc_shift;
        end
      end else if (lim || (cnt_ext >= eff_limit)) begin
        lim_next = 1'b1;
      end else if (!data_byte[7]) begin
        push       = 1'b1;
        entry.ch0  = data_byte;
        entry.cnt0 = cnt_p1;
        cnt_next   = cnt_p1;
      end else if ((data_byte & 8'hE0) == 8'hC0) begin
        acc_next  = {16'b0, data_byte[4:0]};
        pend_next = 2'd1;
      end else if ((data_byte & 8'hF0) == 8'hE0) begin
        acc_next  = {17'b0, data_byte[3:0]};
        pend_next = 2'd2;
      end else if ((data_byte & 8'hF8) == 8'hF0) begin
        acc_next  = {18'b0, data_byte[2:0]};
        pend_next = 2'd3;
      end else begin
        // Stray lead byte.
        push       = 1'b1;
        entry.ch0  = SUBST_CHAR;
        entry.cnt0 = cnt_p1;
        cnt_next   = cnt_p1;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/u8l1_queue.sv]
`default_nettype none
module u8l1_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire u8l1_pkg::u8l1_entry_t push_data,
  output      logic                  full,
  input  wire logic                  pop,
  output      logic                  not_empty,
  output      u8l1_pkg::u8l1_entry_t pop_data
);
  import u8l1_pkg::*;

  u8l1_entry_t         slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr, rptr;
  logic [QUEUE_CW-1:0] fill;

  assign full      = (fill == QUEUE_CW'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign pop_data  = slots[rptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + QUEUE_AW'(1);
      if (pop) rptr <= rptr + QUEUE_AW'(1);
      if (push && !pop) fill <= fill + QUEUE_CW'(1);
      else if (pop && !push) fill <= fill - QUEUE_CW'(1);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_data;
  end

endmodule
`default_nettype wire

[hdl/u8l1_back.sv]
`default_nettype none
module u8l1_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_valid,
  input  wire u8l1_pkg::u8l1_entry_t q_data,
  output      logic                  q_pop,
  u8l1_out_if.source                 out_ch
);
  import u8l1_pkg::*;

  u8l1_entry_t cur;
  logic        cur_valid;
  logic        sel;
  logic        done;

  // The entry is finished when its last item is taken.
  assign done  = cur_valid && out_ch.ready && (sel || !cur.two);
  assign q_pop = q_valid && (!cur_valid || done);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      sel       <= 1'b0;
    end else if (done) begin
      cur_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (cur_valid && out_ch.ready) begin
      sel <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
  end

  // Present the first or the second item of the held entry.
  assign out_ch.valid         = cur_valid;
  assign out_ch.out_byte      = sel ? cur.ch1 : cur.ch0;
  assign out_ch.emitted_count = OUT_COUNT_WIDTH'(sel ? cur.cnt1 : cur.cnt0);
  assign out_ch.is_last       = sel ? cur.last1 : cur.last0;

endmodule
`default_nettype wire

[hdl/u8l1_checker.sv]
`default_nettype none
module u8l1_checker (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic [u8l1_pkg::BYTE_WIDTH-1:0]      out_byte,
  input wire logic [u8l1_pkg::OUT_COUNT_WIDTH-1:0] emitted_count,
  input wire logic                                 is_last
);
  import u8l1_pkg::*;

  logic                       out_take;
  logic [OUT_COUNT_WIDTH-1:0] prev_count;

  assign out_take = out_valid && out_ready;

  // Count of the last converted item of the current string.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_count <= '0;
    end else if (out_take) begin
      prev_count <= is_last ? '0 : emitted_count;
    end
  end

  // A stalled output item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(emitted_count)
      && $stable(is_last))
    else $error("output item changed while stalled");

  // Converted items count up by one within a string.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    out_take && !is_last |-> emitted_count == prev_count + OUT_COUNT_WIDTH'(1))
    else $error("emitted count did not step by one");

  // The final item carries the string length and a zero byte.
  a_last_count: assert property (@(posedge clk) disable iff (rst)
    out_take && is_last |-> emitted_count == prev_count && out_byte == '0)
    else $error("final item does not match the string");

  // Nothing comes out right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind utf8_latin1_name_transcoder u8l1_checker checker_inst (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_byte      (out_ch.out_byte),
  .emitted_count (out_ch.emitted_count),
  .is_last       (out_ch.is_last)
);
`default_nettype wire
